// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the same cycle
`define ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ----- src/sha_pkg.sv -----
// sha-256 constants, a rotate-right helper and shared types
// no dependencies
package sha_pkg;
	localparam int unsigned NumRounds = 64;
	localparam int unsigned QueueDepth = 4;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic byte_valid;
		logic end_of_message;
	} in_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_UPDATE, ST_OUT
	} back_state_t;

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenStart = 6'd56;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ----- src/sha_stream_if.sv -----
// valid/ready channel carrying a generic payload
// depends on nothing
interface sha_stream_if #(parameter int unsigned Width = 8);
	logic valid;
	logic ready;
	logic [Width-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/sha_front.sv -----
// front part: accepts input words and queues them for the back part
// depends on sha_pkg
module sha_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] in_data_byte,
	input  logic in_byte_valid,
	input  logic in_end_of_message,
	input  logic in_valid,
	output logic in_ready,
	output sha_pkg::in_item_t q_item,
	output logic q_valid,
	input  logic q_take
);
	import sha_pkg::*;
	localparam int unsigned PtrW = $clog2(QueueDepth);

	in_item_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0] cnt_q;
	logic push, pop;

	// words that carry nothing are dropped here
	assign in_ready = (cnt_q != (PtrW+1)'(QueueDepth));
	assign push = in_valid && in_ready && (in_byte_valid || in_end_of_message);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_take;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= '{in_data_byte, in_byte_valid, in_end_of_message};
	end
endmodule

// ----- src/sha_back.sv -----
// back part: block buffering, padding, 64-round compression and digest output
// depends on sha_pkg
module sha_back (
	input  logic clk,
	input  logic arst_n,
	input  sha_pkg::in_item_t q_item,
	input  logic q_valid,
	output logic q_take,
	output logic [31:0] out_digest_word,
	output logic out_digest_last,
	output logic out_valid,
	input  logic out_ready
);
	import sha_pkg::*;

	back_state_t state_q, state_d;
	word_t blk_q [16];
	word_t w_q [16];
	word_t h_q [8];
	word_t v_q [8];
	logic [5:0] fill_q;
	logic [5:0] rnd_q;
	logic [60:0] count_q;
	logic [63:0] bits_q;
	logic fin_q;
	logic pad_done_q, len_done_q;
	logic [2:0] oidx_q;

	logic [7:0] wr_byte;
	logic wr_en, blk_full;
	word_t s0, s1, w_new, t1, t2, wcur;

	assign blk_full = (fill_q == 6'd63);
	assign wcur = w_q[0];
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + wcur;
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign q_take = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) begin
				if (q_item.byte_valid && blk_full) state_d = ST_ROUND;
				else if (q_item.end_of_message) state_d = ST_PAD;
			end
			ST_PAD: if (blk_full) state_d = ST_ROUND;
				else if (fill_q == 6'd55) state_d = ST_LEN;
			ST_LEN: if (blk_full) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'(NumRounds - 1)) state_d = ST_UPDATE;
			// in ST_UPDATE, a set len_done_q means the block just compressed was the length block
			ST_UPDATE: if (fin_q && len_done_q) state_d = ST_OUT;
				else if (fin_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			ST_OUT: if (out_ready && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// byte written into the block this cycle
	always_comb begin
		wr_en = 1'b0;
		wr_byte = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				wr_en = q_valid && q_item.byte_valid;
				wr_byte = q_item.data_byte;
			end
			ST_PAD: begin
				wr_en = 1'b1;
				wr_byte = pad_done_q ? 8'h00 : PadByte;
			end
			ST_LEN: begin
				wr_en = 1'b1;
				wr_byte = bits_q[63:56];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			count_q <= '0;
			fin_q <= 1'b0;
			pad_done_q <= 1'b0;
			len_done_q <= 1'b0;
			oidx_q <= '0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
		end else begin
			state_q <= state_d;
			if (wr_en) fill_q <= fill_q + 6'd1;
			if (state_q == ST_IDLE && q_valid) begin
				if (q_item.byte_valid) count_q <= count_q + 61'd1;
				if (q_item.end_of_message) begin
					fin_q <= 1'b1;
					pad_done_q <= 1'b0;
					len_done_q <= 1'b0;
				end
			end
			if (state_q == ST_PAD) pad_done_q <= 1'b1;
			if (state_q == ST_LEN && blk_full) len_done_q <= 1'b1;
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_UPDATE) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (state_q == ST_OUT && out_ready) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
					count_q <= '0;
					fin_q <= 1'b0;
					len_done_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_item.end_of_message)
			bits_q <= {count_q + 61'(q_item.byte_valid), 3'b000};
		if (state_q == ST_LEN) bits_q <= {bits_q[55:0], 8'h00};
		if (wr_en) blk_q[fill_q[5:2]] <= (fill_q[1:0] == 2'd0) ?
			{wr_byte, 24'h0} : (blk_q[fill_q[5:2]] | (word_t'(wr_byte) << (8 * (3 - fill_q[1:0]))));
		if (state_d == ST_ROUND && state_q != ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= blk_q[i];
			w_q[15] <= (fill_q[1:0] == 2'd3) ? {blk_q[15][31:8], wr_byte} : blk_q[15];
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_digest_word = h_q[oidx_q];
	assign out_digest_last = (oidx_q == 3'd7);
endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
// sha-256 byte stream hasher top level
// depends on sha_pkg, sha_stream_if, sha_front, sha_back
//
// input channel in: one word per item holding data_byte, byte_valid and
// end_of_message. output channel out: digest_word and digest_last.
// the front queue takes words while the back part compresses.
// a full block is taken byte by byte in ST_IDLE, then compressed in ST_ROUND
// and added into the hash in ST_UPDATE; the back part takes no bytes while
// it compresses or updates the hash.
// at end of message the back part pads one byte a cycle and runs one or two
// compressions; the first digest word appears in ST_OUT, which follows the
// ST_UPDATE of the last compression. it then presents eight digest
// words, word 0 first, the last with digest_last set. a stalled receiver
// holds the current word and the back part; the queue keeps accepting until
// it holds four words.
// reset clears the queue and loads the initial hash values.
module sha256_byte_stream_hasher (
	input logic clk,
	input logic arst_n,
	sha_stream_if.sink in,
	sha_stream_if.source out
);
	import sha_pkg::*;
	in_item_t q_item;
	logic q_valid, q_take;

	sha_front u_front (
		.clk, .arst_n,
		.in_data_byte(in.payload[9:2]),
		.in_byte_valid(in.payload[1]),
		.in_end_of_message(in.payload[0]),
		.in_valid(in.valid),
		.in_ready(in.ready),
		.q_item, .q_valid, .q_take
	);

	sha_back u_back (
		.clk, .arst_n,
		.q_item, .q_valid, .q_take,
		.out_digest_word(out.payload[32:1]),
		.out_digest_last(out.payload[0]),
		.out_valid(out.valid),
		.out_ready(out.ready)
	);
endmodule

// ----- src/sha_checker.sv -----
// port-level checker for the hasher, bound to the top level
// depends on assert_macros.svh and sha_stream_if
`include "assert_macros.svh"
module sha_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [32:0] out_payload
);
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_payload))
	`ASSERT_NEXT(a_last_ends, clk, arst_n, out_valid && out_ready && out_payload[0], !out_valid || !out_payload[0])
	`ASSERT_NEXT(a_not_last_next, clk, arst_n, out_valid && out_ready && !out_payload[0], out_valid)
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (
	.clk, .arst_n,
	.out_valid(out.valid), .out_ready(out.ready), .out_payload(out.payload)
);
